[rtl/core/dda_pkg.sv]
// Shared types, constants, division step and colour blend functions for the DDA line rasteriser.
package dda_pkg;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 1024;

    localparam logic signed [32:0] X_LIMIT = 33'(SCREEN_WIDTH * 65536);
    localparam logic signed [32:0] Y_LIMIT = 33'(SCREEN_HEIGHT * 65536);

    localparam logic [31:0] PAIR_MASK      = 32'h00FF_00FF;
    localparam logic [31:0] FULL_WEIGHT_Q16 = 32'h00FF_0000;

    localparam int DIV_ITERS = 32;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic iter;
        logic finish;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic line_active;
        logic last_pix;
    } t_sts;

    typedef struct packed {
        logic [17:0] rem;
        logic [31:0] quo;
    } t_lane;

    // one restoring division step; quotient bits shift in as dividend bits shift out
    function automatic t_lane div_bit(t_lane cur, logic [16:0] d);
        logic [17:0] trial;
        t_lane       nxt;
        trial = {cur.rem[16:0], cur.quo[31]};
        if (trial >= {1'b0, d}) begin
            nxt.rem = trial - {1'b0, d};
            nxt.quo = {cur.quo[30:0], 1'b1};
        end else begin
            nxt.rem = trial;
            nxt.quo = {cur.quo[30:0], 1'b0};
        end
        return nxt;
    endfunction

    // paired-channel modular lerp, weight w out of 256
    function automatic logic [31:0] blend(logic [31:0] from_c, logic [31:0] to_c,
                                          logic [7:0] w);
        logic [31:0] rb;
        logic [31:0] ga;
        logic [31:0] drb;
        logic [31:0] dga;
        logic [31:0] prb;
        logic [31:0] pga;
        rb  = from_c & PAIR_MASK;
        ga  = (from_c >> 8) & PAIR_MASK;
        drb = (to_c & PAIR_MASK) - rb;
        dga = ((to_c >> 8) & PAIR_MASK) - ga;
        prb = drb * {24'd0, w};
        pga = dga * {24'd0, w};
        rb  = rb + (prb >> 8);
        ga  = ga + (pga >> 8);
        return (rb & PAIR_MASK) | ((ga & PAIR_MASK) << 8);
    endfunction

endpackage

[rtl/core/dda_if.sv]
// Valid/ready channel interfaces for line commands and pixel results.
interface dda_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [31:0]        start_color;
    logic [31:0]        end_color;

    modport source (output valid, op, start_x, start_y, end_x, end_y, start_color, end_color,
                    input ready);
    modport sink (input valid, op, start_x, start_y, end_x, end_y, start_color, end_color,
                  output ready);
endinterface

interface dda_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pix_x;
    logic [15:0] pix_y;
    logic [31:0] pix_color;
    logic        on_screen;
    logic        last;

    modport source (output valid, pix_x, pix_y, pix_color, on_screen, last, input ready);
    modport sink (input valid, pix_x, pix_y, pix_color, on_screen, last, output ready);
endinterface

[rtl/core/dda_line_with_color_gradient.sv]
// DDA line rasteriser with a colour gradient. A start transfer (op 0) loads both endpoints
// and colours and runs a three-lane radix-2 divider, one quotient bit per cycle, to form
// the Q16.16 x/y increments and the blend-weight increment; the command channel is held
// off after the start transfer while the divider runs and through the finish state. Each
// step transfer (op 1) then yields one pixel per cycle, limited only by the single output
// register draining, until the final pixel, flagged by last. Step transfers with no line
// loaded are taken and dropped.
module dda_line_with_color_gradient (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dda_in_if.sink           i_in,
    dda_out_if.source        o_out
);
    import dda_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    logic in_xfer;

    dda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    dda_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_start_x     (i_in.start_x),
        .i_start_y     (i_in.start_y),
        .i_end_x       (i_in.end_x),
        .i_end_y       (i_in.end_y),
        .i_start_color (i_in.start_color),
        .i_end_color   (i_in.end_color),
        .o_sts         (sts),
        .o_pix_x       (o_out.pix_x),
        .o_pix_y       (o_out.pix_y),
        .o_pix_color   (o_out.pix_color),
        .o_on_screen   (o_out.on_screen),
        .o_last        (o_out.last)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign in_xfer     = i_in.valid && in_ready;

`ifndef ASSERT_OFF
    a_emit_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out.valid)
        else $error("pixel emitted but output slot not filled");

    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.op == OP_START) |=> !i_in.ready)
        else $error("command channel ready while divider running");

    a_emit_needs_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.line_active)
        else $error("pixel emitted with no line loaded");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && sts.last_pix) |=> !sts.line_active)
        else $error("line still active after final pixel");
`endif

endmodule

[rtl/core/dda_ctrl.sv]
// Controller: handshakes, divider sequencing and output slot occupancy.
module dda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    input  logic          i_out_ready,
    input  dda_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output dda_pkg::t_cmd o_cmd
);
    import dda_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        slot_free   = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = slot_free;
                if (i_in_valid && slot_free) begin
                    if (i_in_op == OP_START) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_DIV;
                    end else if (i_sts.line_active) begin
                        o_cmd.emit  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.iter = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/core/dda_dpath.sv]
// Datapath: line state, three-lane radix-2 divider, stepper and pixel output register.
module dda_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dda_pkg::t_cmd      i_cmd,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic [31:0]        i_start_color,
    input  logic [31:0]        i_end_color,
    output dda_pkg::t_sts      o_sts,
    output logic [15:0]        o_pix_x,
    output logic [15:0]        o_pix_y,
    output logic [31:0]        o_pix_color,
    output logic               o_on_screen,
    output logic               o_last
);
    import dda_pkg::*;

    logic signed [32:0] r_pos_x;
    logic signed [32:0] r_pos_y;
    logic signed [32:0] r_step_x;
    logic signed [32:0] r_step_y;
    logic [23:0]        r_alpha_acc;
    logic [23:0]        r_alpha_step;
    logic [16:0]        r_steps_left;
    logic [31:0]        r_color_a;
    logic [31:0]        r_color_b;
    logic               r_line_active;
    logic [16:0]        r_count;
    logic               r_neg_x;
    logic               r_neg_y;
    t_lane              r_lx;
    t_lane              r_ly;
    t_lane              r_la;
    logic [4:0]         r_iter;

    logic [15:0] r_pix_x;
    logic [15:0] r_pix_y;
    logic [31:0] r_pix_color;
    logic        r_on_screen;
    logic        r_last;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]        ax;
    logic [16:0]        ay;
    logic [16:0]        count;
    logic               vis;
    logic               last_pix;

    assign dx    = 17'(i_end_x) - 17'(i_start_x);
    assign dy    = 17'(i_end_y) - 17'(i_start_y);
    assign ax    = dx[16] ? 17'(-dx) : 17'(dx);
    assign ay    = dy[16] ? 17'(-dy) : 17'(dy);
    assign count = ((ax > ay) ? ax : ay) + 17'd1;

    assign vis = !r_pos_x[32] && !r_pos_y[32] && (r_pos_x < X_LIMIT) && (r_pos_y < Y_LIMIT);
    assign last_pix = r_steps_left == 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_iter        <= '0;
        end else begin
            if (i_cmd.load) begin
                r_line_active <= 1'b1;
                r_iter        <= '0;
            end else begin
                if (i_cmd.iter) begin
                    r_iter <= r_iter + 5'd1;
                end
                if (i_cmd.emit && last_pix) begin
                    r_line_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos_x      <= {i_start_x[15], i_start_x, 16'd0};
            r_pos_y      <= {i_start_y[15], i_start_y, 16'd0};
            r_alpha_acc  <= '0;
            r_steps_left <= count;
            r_count      <= count;
            r_color_a    <= i_start_color;
            r_color_b    <= i_end_color;
            r_neg_x      <= dx[16];
            r_neg_y      <= dy[16];
            r_lx.rem     <= '0;
            r_lx.quo     <= {ax[15:0], 16'd0};
            r_ly.rem     <= '0;
            r_ly.quo     <= {ay[15:0], 16'd0};
            r_la.rem     <= '0;
            r_la.quo     <= FULL_WEIGHT_Q16;
        end
        if (i_cmd.iter) begin
            r_lx <= div_bit(r_lx, r_count);
            r_ly <= div_bit(r_ly, r_count);
            r_la <= div_bit(r_la, r_count);
        end
        if (i_cmd.finish) begin
            r_step_x     <= r_neg_x ? -$signed({1'b0, r_lx.quo}) : $signed({1'b0, r_lx.quo});
            r_step_y     <= r_neg_y ? -$signed({1'b0, r_ly.quo}) : $signed({1'b0, r_ly.quo});
            r_alpha_step <= r_la.quo[23:0];
        end
        if (i_cmd.emit) begin
            r_pix_x      <= vis ? r_pos_x[31:16] : 16'd0;
            r_pix_y      <= vis ? r_pos_y[31:16] : 16'd0;
            r_pix_color  <= blend(r_color_a, r_color_b, r_alpha_acc[23:16]);
            r_on_screen  <= vis;
            r_last       <= last_pix;
            r_steps_left <= r_steps_left - 17'd1;
            r_alpha_acc  <= r_alpha_acc + r_alpha_step;
            r_pos_x      <= r_pos_x + r_step_x;
            r_pos_y      <= r_pos_y + r_step_y;
        end
    end

    assign o_sts.div_last    = r_iter == 5'(DIV_ITERS - 1);
    assign o_sts.line_active = r_line_active;
    assign o_sts.last_pix    = last_pix;

    assign o_pix_x     = r_pix_x;
    assign o_pix_y     = r_pix_y;
    assign o_pix_color = r_pix_color;
    assign o_on_screen = r_on_screen;
    assign o_last      = r_last;

endmodule
